[hdl/mseu_pkg.sv]
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared types and constants of the MIPS subset execute unit: opcodes,
// function codes, memory sizes and the request and result records.
// ----------------------------------------------------------------------------
package mseu_pkg;

    // Data memory depth in words; must be a power of two (index is a bit slice)
    localparam int DATA_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [REG_AW-1:0] LINK_REG = 5'd31;
    localparam int REGION_SHIFT = 28;
    localparam int HALF_SHIFT   = 16;

    // Opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-type function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // Configuration register indexes
    localparam logic REG_START_ADDRESS = 1'b0;

    typedef struct packed {
        logic              unknown_instr;
        logic [31:0]       next_pc;
        logic              reg_write_en;
        logic [REG_AW-1:0] reg_write_index;
        logic [31:0]       reg_write_value;
        logic              mem_write_en;
        logic [31:0]       mem_address;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] idx;
        logic [31:0]       data;
    } t_rf_wr;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [DMEM_AW-1:0] idx;
        logic [31:0]        data;
    } t_dm_req;

endpackage

[hdl/mseu_regfile.sv]
// ----------------------------------------------------------------------------
// mseu_regfile
// 32 x 32 register file, one write port and two registered read ports.
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module mseu_regfile
    import mseu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_AW-1:0] i_rd_addr_a,
    input  logic [REG_AW-1:0] i_rd_addr_b,
    input  t_rf_wr            i_wr,
    output logic [31:0]       o_rd_data_a,
    output logic [31:0]       o_rd_data_b
);

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [31:0]          r_data_a;
    logic [31:0]          r_data_b;
    logic                 r_valid_a;
    logic                 r_valid_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_addr_a];
            r_data_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_valid_a <= r_valid[i_rd_addr_a];
                r_valid_b <= r_valid[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_valid_a ? r_data_a : 32'd0;
    assign o_rd_data_b = r_valid_b ? r_data_b : 32'd0;

endmodule

[hdl/mseu_dmem.sv]
// ----------------------------------------------------------------------------
// mseu_dmem
// Word-addressed data memory with a registered read port and a clearing
// pass that zeroes every word, one a cycle, after reset.
// ----------------------------------------------------------------------------
module mseu_dmem
    import mseu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dm_req     i_req,
    output logic [31:0] o_rd_data,
    output logic        o_clr_busy
);

    logic [31:0]        r_mem [DATA_WORDS];
    logic [31:0]        r_rd_data;
    logic [DMEM_AW-1:0] r_clr_idx;
    logic               r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == DMEM_AW'(DATA_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= 32'd0;
        end else if (i_req.we) begin
            r_mem[i_req.idx] <= i_req.data;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.idx];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

[hdl/mseu_result_q.sv]
// ----------------------------------------------------------------------------
// mseu_result_q
// Two-entry result queue: output register plus skid stage, so a finished
// result may wait while the next request is taken.
// ----------------------------------------------------------------------------
module mseu_result_q
    import mseu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                    if (i_push) begin
                        r_skid       <= i_data;
                        r_skid_valid <= 1'b1;
                    end
                end else if (i_push) begin
                    r_out <= i_data;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid) begin
                    r_out       <= i_data;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= i_data;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_out_valid && r_skid_valid;

endmodule

[hdl/mips_subset_instruction_execute_unit.sv]
// Path: a request is registered into the execute stage and its result into the
// output register; lw also passes through the data memory read register.
// A new request waits while one is in the execute stage or a load is completing,
// due to the registered register-file read followed by writeback of the same register file.
// Reset: registers read zero at once; a clearing pass zeroes data memory,
// and no request is taken until it ends.
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute_unit
// Executes one MIPS32 subset instruction per request and reports the
// register write, memory access and next program counter.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_unit
    import mseu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] instr_word
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] next_pc, [32] reg_write_en, [37:33] reg_write_index,
    // [69:38] reg_write_value, [70] mem_write_en, [102:71] mem_address, [103] 0
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tuser,   // [0] unknown_instr
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] r_start_address;
    logic [31:0] r_pc;
    logic        r_s1_valid;
    logic [31:0] r_instr;
    logic        r_ld_pend;
    t_result     r_ld_res;

    logic [31:0] w_rs_data;
    logic [31:0] w_rt_data;
    logic [31:0] w_dm_rdata;
    logic        w_clr_busy;
    logic        w_q_full;
    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_push;
    t_result     w_push_data;
    t_rf_wr      w_rf_wr;
    t_dm_req     w_dm_req;
    t_result     m_q_data;

    // Execute-stage decode
    t_result     n_res;
    logic        n_load;
    logic [5:0]  w_op;
    logic [5:0]  w_fn;
    logic [4:0]  w_sh;
    logic [15:0] w_imm;
    logic [31:0] w_si;
    logic [31:0] w_pc4;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_START_ADDRESS) ? r_start_address : 32'd0;

    assign s_axis_tready = !w_clr_busy && !r_s1_valid && !r_ld_pend && !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_op  = r_instr[31:26];
    assign w_fn  = r_instr[5:0];
    assign w_sh  = r_instr[10:6];
    assign w_imm = r_instr[15:0];
    assign w_si  = {{16{w_imm[15]}}, w_imm};
    assign w_pc4 = r_pc + 32'd4;

    always_comb begin
        n_res                 = '0;
        n_res.next_pc         = w_pc4;
        n_load                = 1'b0;
        if (w_op == OP_RTYPE) begin
            n_res.reg_write_en    = 1'b1;
            n_res.reg_write_index = r_instr[15:11];
            case (w_fn)
                FN_ADD, FN_ADDU: n_res.reg_write_value = w_rs_data + w_rt_data;
                FN_SUB, FN_SUBU: n_res.reg_write_value = w_rs_data - w_rt_data;
                FN_AND:  n_res.reg_write_value = w_rs_data & w_rt_data;
                FN_OR:   n_res.reg_write_value = w_rs_data | w_rt_data;
                FN_SLT:  n_res.reg_write_value =
                             {31'd0, $signed(w_rs_data) < $signed(w_rt_data)};
                FN_SLTU: n_res.reg_write_value = {31'd0, w_rs_data < w_rt_data};
                FN_SLL:  n_res.reg_write_value = w_rt_data << w_sh;
                FN_SRL:  n_res.reg_write_value = w_rt_data >> w_sh;
                FN_JR: begin
                    n_res.reg_write_en = 1'b0;
                    n_res.next_pc      = {w_rs_data[31:2], 2'b00};
                end
                default: begin
                    n_res.reg_write_en  = 1'b0;
                    n_res.unknown_instr = 1'b1;
                end
            endcase
        end else begin
            n_res.reg_write_en    = 1'b1;
            n_res.reg_write_index = r_instr[20:16];
            case (w_op)
                OP_ADDI, OP_ADDIU: n_res.reg_write_value = w_rs_data + w_si;
                OP_ANDI: n_res.reg_write_value = w_rs_data & {16'd0, w_imm};
                OP_ORI:  n_res.reg_write_value = w_rs_data | {16'd0, w_imm};
                OP_LUI:  n_res.reg_write_value = {w_imm, 16'd0};
                OP_SLTI: n_res.reg_write_value =
                             {31'd0, $signed(w_rs_data) < $signed(w_si)};
                OP_SLTIU: n_res.reg_write_value = {31'd0, w_rs_data < w_si};
                OP_BEQ: begin
                    n_res.reg_write_en = 1'b0;
                    if (w_rs_data == w_rt_data) begin
                        n_res.next_pc = w_pc4 + {w_si[29:0], 2'b00};
                    end
                end
                OP_BNE: begin
                    n_res.reg_write_en = 1'b0;
                    if (w_rs_data != w_rt_data) begin
                        n_res.next_pc = w_pc4 + {w_si[29:0], 2'b00};
                    end
                end
                OP_J, OP_JAL: begin
                    n_res.next_pc = {w_pc4[31:REGION_SHIFT], r_instr[25:0], 2'b00};
                    if (w_op == OP_JAL) begin
                        n_res.reg_write_index = LINK_REG;
                        n_res.reg_write_value = w_pc4;
                    end else begin
                        n_res.reg_write_en = 1'b0;
                    end
                end
                OP_LW: begin
                    n_load            = 1'b1;
                    n_res.mem_address = w_rs_data + w_si;
                end
                OP_SW: begin
                    n_res.reg_write_en = 1'b0;
                    n_res.mem_address  = w_rs_data + w_si;
                    n_res.mem_write_en = 1'b1;
                end
                default: begin
                    n_res.reg_write_en  = 1'b0;
                    n_res.unknown_instr = 1'b1;
                end
            endcase
        end
        // Drop writes to register zero
        if (!n_res.reg_write_en || n_res.reg_write_index == '0) begin
            n_res.reg_write_en    = 1'b0;
            n_res.reg_write_index = '0;
            n_res.reg_write_value = 32'd0;
        end
    end

    // Register file write: from the execute stage, or from a finished load
    always_comb begin
        w_rf_wr = '0;
        if (r_ld_pend) begin
            w_rf_wr.en   = r_ld_res.reg_write_en;
            w_rf_wr.idx  = r_ld_res.reg_write_index;
            w_rf_wr.data = w_dm_rdata;
        end else if (r_s1_valid && !n_load) begin
            w_rf_wr.en   = n_res.reg_write_en;
            w_rf_wr.idx  = n_res.reg_write_index;
            w_rf_wr.data = n_res.reg_write_value;
        end
    end

    always_comb begin
        w_dm_req      = '0;
        w_dm_req.idx  = n_res.mem_address[DMEM_AW+1:2];
        w_dm_req.data = w_rt_data;
        w_dm_req.we   = r_s1_valid && n_res.mem_write_en;
        w_dm_req.re   = r_s1_valid && n_load;
    end

    always_comb begin
        w_push      = 1'b0;
        w_push_data = n_res;
        if (r_ld_pend) begin
            w_push      = 1'b1;
            w_push_data = r_ld_res;
            w_push_data.reg_write_value = r_ld_res.reg_write_en ? w_dm_rdata : 32'd0;
        end else if (r_s1_valid && !n_load) begin
            w_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address <= 32'd0;
            r_pc            <= 32'd0;
            r_s1_valid      <= 1'b0;
            r_ld_pend       <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_ld_pend  <= r_s1_valid && n_load;
            if (w_cfg_wr && paddr[2] == REG_START_ADDRESS) begin
                r_start_address <= pwdata;
                r_pc            <= {pwdata[31:2], 2'b00};
            end else if (r_s1_valid) begin
                r_pc <= n_res.next_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_instr <= s_axis_tdata;
        end
        if (r_s1_valid && n_load) begin
            r_ld_res <= n_res;
        end
    end

    mseu_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (s_axis_tdata[25:21]),
        .i_rd_addr_b (s_axis_tdata[20:16]),
        .i_wr        (w_rf_wr),
        .o_rd_data_a (w_rs_data),
        .o_rd_data_b (w_rt_data)
    );

    mseu_dmem u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_dm_req),
        .o_rd_data  (w_dm_rdata),
        .o_clr_busy (w_clr_busy)
    );

    mseu_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_q_data),
        .o_full  (w_q_full)
    );

    assign m_axis_tuser = m_q_data.unknown_instr;
    assign m_axis_tdata = {1'b0,
                           m_q_data.mem_address,
                           m_q_data.mem_write_en,
                           m_q_data.reg_write_value,
                           m_q_data.reg_write_index,
                           m_q_data.reg_write_en,
                           m_q_data.next_pc};

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("result pushed into a full queue");

    a_stage_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_ld_pend))
        else $error("execute stage and load completion overlap");

    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rf_wr.en |-> w_rf_wr.idx != '0)
        else $error("register zero written");

    a_accept_executes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid && !s_axis_tready)
        else $error("accepted request not in execute stage");

endmodule

[test/tb_mips_subset_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_execute_unit
// Streams MIPS subset instructions into the execute unit under several start
// addresses. A behavioural copy of the register file, program counter and
// data memory predicts each result, and the output stream is checked field by
// field against it.
// ----------------------------------------------------------------------------
module tb_mips_subset_instruction_execute_unit
    import mseu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT       = 26;
    localparam int          HOLD_OFF_LEN   = 80;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [2:0]  ADDR_START     = {REG_START_ADDRESS, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
    localparam logic [5:0]  OP_UNUSED      = 6'h3F;
    localparam logic [5:0]  FN_UNUSED      = 6'h3F;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata = '0;   // [31:0] instr_word
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // [31:0] next_pc, [32] reg_write_en, [37:33] reg_write_index,
    // [69:38] reg_write_value, [70] mem_write_en, [102:71] mem_address
    logic [103:0]  m_axis_tdata;
    logic          m_axis_tuser;        // [0] unknown_instr
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    mips_subset_instruction_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Architectural copy of the core
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] pc_model = '0;

    logic [31:0] instr_queue [$];
    t_result     expected_results [$];

    logic steady = 1'b0;
    logic hold_off_req = 1'b0;
    logic instr_taken = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   instrs_executed = 0;
    int   results_checked = 0;
    int   loads_seen = 0;
    int   stores_seen = 0;
    int   redirects_seen = 0;
    int   unknowns_seen = 0;
    int   start_writes = 0;

    initial begin
        for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
        for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
    end

    function automatic int mem_slot(logic [31:0] addr);
        return int'((addr >> 2) % DATA_WORDS);
    endfunction

    function automatic t_result execute_instr(logic [31:0] w);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] si;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic [31:0] npc;
        logic        wr;
        t_result     r;
        op  = w[31:26];
        rs  = w[25:21];
        rt  = w[20:16];
        rd  = w[15:11];
        sh  = w[10:6];
        fn  = w[5:0];
        imm = w[15:0];
        si  = {{16{imm[15]}}, imm};
        a   = gpr[rs];
        b   = gpr[rt];
        pc4 = pc_model + 32'd4;
        npc = pc4;
        r   = '0;
        wr  = 1'b1;
        if (op == OP_RTYPE) begin
            r.reg_write_index = rd;
            case (fn)
                FN_ADD, FN_ADDU: r.reg_write_value = a + b;
                FN_SUB, FN_SUBU: r.reg_write_value = a - b;
                FN_AND:          r.reg_write_value = a & b;
                FN_OR:           r.reg_write_value = a | b;
                FN_SLT:          r.reg_write_value = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU:         r.reg_write_value = {31'd0, a < b};
                FN_SLL:          r.reg_write_value = b << sh;
                FN_SRL:          r.reg_write_value = b >> sh;
                FN_JR: begin
                    wr  = 1'b0;
                    npc = {a[31:2], 2'b00};
                end
                default: begin
                    wr = 1'b0;
                    r.unknown_instr = 1'b1;
                end
            endcase
        end else begin
            r.reg_write_index = rt;
            case (op)
                OP_ADDI, OP_ADDIU: r.reg_write_value = a + si;
                OP_ANDI:  r.reg_write_value = a & {16'd0, imm};
                OP_ORI:   r.reg_write_value = a | {16'd0, imm};
                OP_LUI:   r.reg_write_value = {16'd0, imm} << HALF_SHIFT;
                OP_SLTI:  r.reg_write_value = {31'd0, $signed(a) < $signed(si)};
                OP_SLTIU: r.reg_write_value = {31'd0, a < si};
                OP_BEQ: begin
                    wr = 1'b0;
                    if (a == b) npc = pc4 + (si << 2);
                end
                OP_BNE: begin
                    wr = 1'b0;
                    if (a != b) npc = pc4 + (si << 2);
                end
                OP_J, OP_JAL: begin
                    npc = {pc4[31:REGION_SHIFT], w[25:0], 2'b00};
                    if (op == OP_JAL) begin
                        r.reg_write_index = LINK_REG;
                        r.reg_write_value = pc4;
                    end else begin
                        wr = 1'b0;
                    end
                end
                OP_LW: begin
                    r.mem_address     = a + si;
                    r.reg_write_value = dmem[mem_slot(r.mem_address)];
                    loads_seen++;
                end
                OP_SW: begin
                    wr = 1'b0;
                    r.mem_address  = a + si;
                    r.mem_write_en = 1'b1;
                    dmem[mem_slot(r.mem_address)] = b;
                    stores_seen++;
                end
                default: begin
                    wr = 1'b0;
                    r.unknown_instr = 1'b1;
                end
            endcase
        end
        if (!wr || r.reg_write_index == '0) begin
            r.reg_write_index = '0;
            r.reg_write_value = '0;
        end else begin
            r.reg_write_en = 1'b1;
            gpr[r.reg_write_index] = r.reg_write_value;
        end
        if (r.unknown_instr) unknowns_seen++;
        if (npc != pc4) redirects_seen++;
        r.next_pc = npc;
        pc_model  = npc;
        return r;
    endfunction

    task automatic check_result(t_result exp_r, t_result act);
        if (act.unknown_instr !== exp_r.unknown_instr) begin
            $error("unknown_instr: expected %0h, got %0h", exp_r.unknown_instr,
                   act.unknown_instr);
            error_count++;
        end
        if (act.next_pc !== exp_r.next_pc) begin
            $error("next_pc: expected %h, got %h", exp_r.next_pc, act.next_pc);
            error_count++;
        end
        if (act.reg_write_en !== exp_r.reg_write_en) begin
            $error("reg_write_en: expected %0h, got %0h", exp_r.reg_write_en,
                   act.reg_write_en);
            error_count++;
        end
        if (act.reg_write_index !== exp_r.reg_write_index) begin
            $error("reg_write_index: expected %0d, got %0d", exp_r.reg_write_index,
                   act.reg_write_index);
            error_count++;
        end
        if (act.reg_write_value !== exp_r.reg_write_value) begin
            $error("reg_write_value: expected %h, got %h", exp_r.reg_write_value,
                   act.reg_write_value);
            error_count++;
        end
        if (act.mem_write_en !== exp_r.mem_write_en) begin
            $error("mem_write_en: expected %0h, got %0h", exp_r.mem_write_en,
                   act.mem_write_en);
            error_count++;
        end
        if (act.mem_address !== exp_r.mem_address) begin
            $error("mem_address: expected %h, got %h", exp_r.mem_address,
                   act.mem_address);
            error_count++;
        end
    endtask

    // Sample every handshake at the rising edge
    always @(posedge i_clk) begin
        t_result act;
        if (m_axis_tvalid && m_axis_tready) begin
            act.unknown_instr   = m_axis_tuser;
            act.next_pc         = m_axis_tdata[31:0];
            act.reg_write_en    = m_axis_tdata[32];
            act.reg_write_index = m_axis_tdata[37:33];
            act.reg_write_value = m_axis_tdata[69:38];
            act.mem_write_en    = m_axis_tdata[70];
            act.mem_address     = m_axis_tdata[102:71];
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                check_result(expected_results.pop_front(), act);
                results_checked++;
            end
        end
        instr_taken = s_axis_tvalid && s_axis_tready;
        if (instr_taken) begin
            expected_results.push_back(execute_instr(s_axis_tdata));
            instrs_executed++;
        end
        if (psel && penable && pwrite && pready && paddr == ADDR_START) begin
            pc_model = {pwdata[31:2], 2'b00};
            start_writes++;
        end
        if (instr_taken || (m_axis_tvalid && m_axis_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || instr_taken) begin
            if (instr_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tdata  <= instr_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 75) return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [15:0] pick_imm();
        if ($urandom_range(99) < 30) return 16'($urandom_range(15)) - 16'd4;
        return 16'($urandom());
    endfunction

    function automatic bit opcode_known(logic [5:0] op);
        case (op)
            OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI,
            OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit funct_known(logic [5:0] fn);
        case (fn)
            FN_SLL, FN_SRL, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
            FN_SLT, FN_SLTU: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Mostly well-formed instructions over a small working set of registers
    function automatic logic [31:0] random_instr();
        int unsigned kind;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        kind = $urandom_range(99);
        if (kind < 7) return $urandom();
        if (kind < 11) begin
            do op = 6'($urandom()); while (opcode_known(op));
            return {op, 26'($urandom())};
        end
        if (kind < 14) begin
            do fn = 6'($urandom()); while (funct_known(fn));
            return {OP_RTYPE, 20'($urandom()), fn};
        end
        if (kind < 44) begin
            case ($urandom_range(9))
                0: fn = FN_ADD;
                1: fn = FN_ADDU;
                2: fn = FN_SUB;
                3: fn = FN_SUBU;
                4: fn = FN_AND;
                5: fn = FN_OR;
                6: fn = FN_SLT;
                7: fn = FN_SLTU;
                8: fn = FN_SLL;
                default: fn = FN_SRL;
            endcase
            return enc_r(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom()));
        end
        if (kind < 47) return enc_r(FN_JR, pick_reg(), 5'($urandom()), 5'($urandom()),
                                    5'($urandom()));
        if (kind < 72) begin
            case ($urandom_range(6))
                0: op = OP_ADDI;
                1: op = OP_ADDIU;
                2: op = OP_ANDI;
                3: op = OP_ORI;
                4: op = OP_LUI;
                5: op = OP_SLTI;
                default: op = OP_SLTIU;
            endcase
            return enc_i(op, pick_reg(), pick_reg(), pick_imm());
        end
        if (kind < 80) begin
            op = $urandom_range(1) ? OP_BEQ : OP_BNE;
            rs = pick_reg();
            return enc_i(op, rs, $urandom_range(1) ? rs : pick_reg(), pick_imm());
        end
        if (kind < 84) return {$urandom_range(1) ? OP_JAL : OP_J, 26'($urandom())};
        op = $urandom_range(1) ? OP_LW : OP_SW;
        // Half the accesses land in a few words so loads see earlier stores
        if ($urandom_range(1)) return enc_i(op, 5'd0, pick_reg(), 16'($urandom_range(63)));
        return enc_i(op, pick_reg(), pick_reg(), pick_imm());
    endfunction

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (instr_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic run_random(logic [31:0] start_addr, int count, bit rush, bit hold);
        int mark;
        wait_drained();
        // let the last lw retire through its data memory read
        repeat (4) @(negedge i_clk);
        cfg_write(ADDR_START, start_addr);
        steady = rush;
        mark   = instrs_executed;
        for (int i = 0; i < count; i++) instr_queue.push_back(random_instr());
        if (hold) begin
            while (instrs_executed < mark + 5) @(negedge i_clk);
            @(posedge i_clk);
            hold_off_req = 1'b1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass from address zero
        cfg_write(ADDR_UNUSED, $urandom());
        cfg_write(ADDR_START, 32'h0000_0000);
        instr_queue.push_back(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF));
        instr_queue.push_back(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        instr_queue.push_back(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h7FFF));
        instr_queue.push_back(enc_i(OP_LUI, 5'd0, 5'd3, 16'h8000));
        // wrap on add, and a stray shift amount that must be ignored
        instr_queue.push_back(enc_r(FN_ADD, 5'd1, 5'd3, 5'd4, 5'd7));
        instr_queue.push_back(enc_i(OP_ADDI, 5'd3, 5'd5, 16'hFFFF));
        instr_queue.push_back(enc_r(FN_SUB, 5'd0, 5'd3, 5'd6, 5'd0));
        instr_queue.push_back(enc_r(FN_SUBU, 5'd2, 5'd1, 5'd7, 5'd0));
        instr_queue.push_back(enc_r(FN_AND, 5'd1, 5'd2, 5'd8, 5'd0));
        instr_queue.push_back(enc_r(FN_OR, 5'd3, 5'd2, 5'd9, 5'd0));
        instr_queue.push_back(enc_r(FN_SLT, 5'd3, 5'd2, 5'd10, 5'd0));
        instr_queue.push_back(enc_r(FN_SLTU, 5'd3, 5'd2, 5'd11, 5'd0));
        instr_queue.push_back(enc_i(OP_SLTI, 5'd1, 5'd12, 16'h0000));
        instr_queue.push_back(enc_i(OP_SLTIU, 5'd2, 5'd13, 16'hFFFF));
        instr_queue.push_back(enc_i(OP_ANDI, 5'd1, 5'd14, 16'hFFFF));
        instr_queue.push_back(enc_r(FN_SLL, 5'd0, 5'd1, 5'd15, 5'd31));
        instr_queue.push_back(enc_r(FN_SRL, 5'd0, 5'd1, 5'd16, 5'd31));
        // write to the zero register is dropped
        instr_queue.push_back(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h0005));
        // top word of the address space, then misaligned and wrapped indexes
        instr_queue.push_back(enc_i(OP_SW, 5'd0, 5'd1, 16'hFFFC));
        instr_queue.push_back(enc_i(OP_LW, 5'd0, 5'd17, 16'hFFFC));
        instr_queue.push_back(enc_i(OP_SW, 5'd0, 5'd3, 16'h0003));
        instr_queue.push_back(enc_i(OP_LW, 5'd0, 5'd18, 16'h1000));
        instr_queue.push_back(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000));
        instr_queue.push_back(enc_i(OP_BNE, 5'd1, 5'd0, 16'hFFFF));
        instr_queue.push_back({OP_JAL, 26'h3FF_FFFF});
        instr_queue.push_back({OP_J, 26'h000_0000});
        // jump through a misaligned register with a junk rt field
        instr_queue.push_back(enc_r(FN_JR, 5'd1, 5'd9, 5'd0, 5'd0));
        instr_queue.push_back({OP_UNUSED, 26'h155_5555});
        instr_queue.push_back(enc_r(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd0));
        wait_drained();

        run_random(32'hFFFF_FFFC, 200, 1'b0, 1'b1);
        run_random(32'h0040_0003, 300, 1'b1, 1'b0);
        run_random($urandom(), 300, 1'b0, 1'b0);
        run_random(32'h0000_0000, 250, 1'b0, 1'b0);

        // leave room for a stray result to show up
        repeat (10) @(negedge i_clk);
        $display("Ran %0d instructions from %0d start addresses, %0d results checked",
                 instrs_executed, start_writes, results_checked);
        $display("Covered %0d loads, %0d stores, %0d control transfers, %0d unknown words",
                 loads_seen, stores_seen, redirects_seen, unknowns_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
